// ----- rtl/core/ird_pkg.sv -----
`default_nettype none

package ird_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  // Command opcodes
  localparam logic [1:0] OP_PUSH_REAR = 2'd0;
  localparam logic [1:0] OP_POP_FRONT = 2'd1;
  localparam logic [1:0] OP_POP_REAR  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_value;
    logic [OCC_W-1:0]         occupancy;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/ird_ram.sv -----
`default_nettype none

module ird_ram import ird_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/input_restricted_deque.sv -----
`default_nettype none
// Input-restricted deque: push at the rear, pop at the front or the rear.
// The result strobe (done) rises in the cycle after the command transfer.
// Throughput: one command per cycle; busy stays low, the receiver cannot stall.
// Reset (rst, synchronous, active high): deque empty, pointers at zero;
// storage contents are not cleared and are undefined until pushed.

module input_restricted_deque import ird_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire cmd_t command,
  output logic      done,
  output result_t   result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  // Pointer/count state. front marks the oldest entry, rear the newest.
  logic [AW-1:0] front, front_next;
  logic [AW-1:0] rear, rear_next;
  logic [CW-1:0] count, count_next;

  // Result side registers
  logic             pop_hit;
  logic [1:0]       status;
  logic [OCC_W-1:0] occupancy;

  logic              accept;
  logic              is_empty;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [1:0]        status_next;
  logic [DATA_W-1:0] rd_data;

  // Every command resolves in its transfer cycle against the pointer
  // registers, so nothing ever needs to hold the requester off.
  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_empty = (count == '0);

  always_comb begin
    front_next  = front;
    rear_next   = rear;
    count_next  = count;
    status_next = ST_DONE;
    wr_en       = 1'b0;
    wr_addr     = rear;
    rd_en       = 1'b0;
    rd_addr     = front;
    case (command.opcode)
      OP_PUSH_REAR: begin
        if (count == FULL_COUNT) begin
          status_next = ST_FULL;
        end else if (is_empty) begin
          // first entry always lands at slot zero
          front_next = '0;
          rear_next  = '0;
          wr_en      = 1'b1;
          wr_addr    = '0;
          count_next = CW'(1);
        end else begin
          rear_next  = (rear == LAST) ? '0 : rear + AW'(1);
          wr_en      = 1'b1;
          wr_addr    = rear_next;
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = (command.opcode == OP_POP_FRONT) ? front : rear;
          count_next = count - CW'(1);
          if (count == CW'(1)) begin
            // last entry out: back to the reset arrangement
            front_next = '0;
            rear_next  = '0;
          end else if (command.opcode == OP_POP_FRONT) begin
            front_next = (front == LAST) ? '0 : front + AW'(1);
          end else begin
            rear_next = (rear == '0) ? LAST : rear - AW'(1);
          end
        end
      end
      default: begin
        // unused opcode: no change, reports current fill
      end
    endcase
  end

  // A pop reads the entry in its own transfer cycle; any push to that entry
  // was written at an earlier edge, so no forwarding is required.
  ird_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (accept && wr_en),
    .waddr (wr_addr),
    .wdata (command.push_value),
    .re    (accept && rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      rear    <= '0;
      count   <= '0;
      done    <= 1'b0;
      pop_hit <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        front   <= front_next;
        rear    <= rear_next;
        count   <= count_next;
        pop_hit <= rd_en;
      end
    end
  end

  // payload side, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign result.status       = status;
  assign result.popped_value = pop_hit ? rd_data : '0;
  assign result.occupancy    = occupancy;

endmodule

`default_nettype wire
